>>> rtl/core/frx_pkg.sv
package frx_pkg;

	// Result tdata width: the packed fields fit in 32 bits for every store depth up to 64 bytes.
	localparam int TDATA_W = 32;

	// Commands from the controller to the datapath, at most one active per cycle.
	typedef struct packed {
		logic cap_cmd;      // hold the command byte
		logic start_frame;  // hold the length, clear the CRC and the byte pointer
		logic data_wr;      // store a payload byte and fold it into the CRC
		logic cap_chk_hi;   // hold the high byte of the received check
		logic emit_empty;   // load the output register with an empty-frame result
		logic emit_start;   // rewind the byte pointer for delivery
		logic emit_rd;      // read the payload store at the byte pointer
		logic emit_load;    // load the output register with the byte just read
	} frx_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic in_zero;      // the incoming byte is zero
		logic len_over;     // the incoming length exceeds the store depth
		logic len_zero;     // the incoming length is zero
		logic left_zero;    // every payload byte of the frame has arrived
		logic crc_match;    // the received check equals the computed CRC
		logic idx_last;     // the byte pointer sits on the final payload byte
		logic out_free;     // the output register can take a result this cycle
	} frx_status_t;

endpackage

>>> rtl/core/frx_dpath.sv
module frx_dpath #(
	parameter int MAX_PAYLOAD = 32,
	parameter int LEN_W       = 6,
	parameter int IDX_W       = 5,
	parameter int TDATA_W     = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frx_pkg::frx_cmd_t    cmd,
	output frx_pkg::frx_status_t status,
	input  logic [7:0]           rx_byte,
	output logic [TDATA_W-1:0]   out_tdata,
	output logic                 out_tuser,
	output logic                 out_tlast,
	output logic                 out_tvalid,
	input  logic                 out_tready
);

	localparam logic [15:0] CRC_POLY = 16'hA001;

	function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	logic [7:0]       command_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] ptr_q;
	logic [15:0]      crc_q;
	logic [7:0]       chk_hi_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       payload_mem [MAX_PAYLOAD];

	logic [7:0]       out_cmd_q;
	logic [LEN_W-1:0] out_len_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [7:0]       out_data_q;
	logic             out_has_q;
	logic             out_last_q;
	logic             out_valid_q;

	logic             out_free;
	logic             out_load;

	assign out_free = !out_valid_q || out_tready;
	assign out_load = cmd.emit_empty || cmd.emit_load;

	always_comb begin
		status.in_zero   = (rx_byte == 8'h00);
		status.len_over  = (rx_byte > 8'(MAX_PAYLOAD));
		status.len_zero  = (rx_byte == 8'h00);
		status.left_zero = (ptr_q == length_q);
		status.crc_match = ({chk_hi_q, rx_byte} == crc_q);
		status.idx_last  = ((ptr_q + LEN_W'(1)) == length_q);
		status.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q <= '0;
			length_q  <= '0;
			ptr_q     <= '0;
			crc_q     <= '0;
			chk_hi_q  <= '0;
		end else begin
			if (cmd.cap_cmd) begin
				command_q <= rx_byte;
			end
			if (cmd.start_frame) begin
				length_q <= rx_byte[LEN_W-1:0];
				ptr_q    <= '0;
				crc_q    <= '0;
			end
			if (cmd.emit_empty) begin
				length_q <= '0;
			end
			if (cmd.data_wr) begin
				crc_q <= crc_arc_byte(crc_q, rx_byte);
				ptr_q <= ptr_q + LEN_W'(1);
			end
			if (cmd.cap_chk_hi) begin
				chk_hi_q <= rx_byte;
			end
			if (cmd.emit_start) begin
				ptr_q <= '0;
			end
			if (cmd.emit_load) begin
				ptr_q <= ptr_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.data_wr) begin
			payload_mem[ptr_q[IDX_W-1:0]] <= rx_byte;
		end
		if (cmd.emit_rd) begin
			rd_data_q <= payload_mem[ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			out_cmd_q  <= command_q;
			out_len_q  <= '0;
			out_idx_q  <= '0;
			out_data_q <= '0;
			out_has_q  <= 1'b0;
			out_last_q <= 1'b1;
		end else if (cmd.emit_load) begin
			out_cmd_q  <= command_q;
			out_len_q  <= length_q;
			out_idx_q  <= ptr_q[IDX_W-1:0];
			out_data_q <= rd_data_q;
			out_has_q  <= 1'b1;
			out_last_q <= status.idx_last;
		end
	end

	assign out_tdata  = TDATA_W'({out_data_q, out_idx_q, out_len_q, out_cmd_q});
	assign out_tuser  = out_has_q;
	assign out_tlast  = out_last_q;
	assign out_tvalid = out_valid_q;

endmodule

>>> rtl/core/frx_ctrl.sv
module frx_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  frx_pkg::frx_status_t status,
	output frx_pkg::frx_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_LEN,
		ST_DATA,
		ST_CHECK,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t state_q;
	logic   in_acc;

	// The length byte may finish an empty frame, so it waits for a free output slot.
	always_comb begin
		unique case (state_q) inside
			ST_WAIT, ST_DATA, ST_CHECK: in_ready = 1'b1;
			ST_LEN:                     in_ready = status.out_free;
			default:                    in_ready = 1'b0;
		endcase
	end

	assign in_acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_WAIT: begin
				cmd.cap_cmd = in_acc && !status.in_zero;
			end
			ST_LEN: begin
				cmd.emit_empty  = in_acc && status.len_zero;
				cmd.start_frame = in_acc && !status.len_zero && !status.len_over;
			end
			ST_DATA: begin
				cmd.data_wr    = in_acc && !status.left_zero;
				cmd.cap_chk_hi = in_acc && status.left_zero;
			end
			ST_CHECK: begin
				cmd.emit_start = in_acc && status.crc_match;
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
			end
			ST_EMIT_LD: begin
				cmd.emit_load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
		end else begin
			unique case (state_q)
				ST_WAIT: begin
					if (in_acc && !status.in_zero) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (in_acc) begin
						if (status.len_over || status.len_zero) begin
							state_q <= ST_WAIT;
						end else begin
							state_q <= ST_DATA;
						end
					end
				end
				ST_DATA: begin
					if (in_acc && status.left_zero) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (in_acc) begin
						state_q <= status.crc_match ? ST_EMIT_RD : ST_WAIT;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (status.out_free) begin
						state_q <= status.idx_last ? ST_WAIT : ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_WAIT;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/framed_packet_receiver_crc16.sv
// Input: one byte per cycle, but none while a good frame is delivered; a length byte waits
// while the output register is still full. An empty frame's result is loaded into the output
// register at the edge accepting its length. After a good frame's low check byte, each of
// its results takes a store read, then an output load that waits for a free output register.
// Reset (arst_n low, asynchronous) returns the receiver to waiting for a command byte and
// empties the output register; the payload store is not cleared.
module framed_packet_receiver_crc16 #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Received byte stream.
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
	// Delivered frame results.
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// From bit 0: command (8), length (LEN_W), byte_index (IDX_W), data_byte (8), zero fill.
	output logic [frx_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic                         m_axis_tuser,   // [0] has_data
	output logic                         m_axis_tlast
);

	// Field widths follow from the payload store depth.
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	// The receiver is split into a controller, which walks the frame format
	// (command, length, payload, check high byte, check low byte) and then
	// sequences delivery, and a datapath, which holds the frame fields, the
	// payload store, the CRC-16/ARC accumulator and the output register.
	//
	// Zero bytes are skipped while a command is awaited. A length above
	// MAX_PAYLOAD drops the frame. A zero length produces a single empty
	// result at once. Otherwise each payload byte is written to the store and
	// folded into the CRC in the cycle its transaction completes. When the
	// two check bytes match the CRC, the stored bytes are read back in order
	// and delivered, the final one flagged with tlast. A mismatch drops the
	// frame without any output.
	//
	// The output register lets the receiver take new bytes while the last
	// result of a frame still waits for the downstream side.

	frx_pkg::frx_cmd_t    cmd;
	frx_pkg::frx_status_t status;

	frx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	frx_dpath #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.LEN_W       (LEN_W),
		.IDX_W       (IDX_W),
		.TDATA_W     (frx_pkg::TDATA_W)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.rx_byte    (s_axis_tdata),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.out_tlast  (m_axis_tlast),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready)
	);

endmodule
